// File: rtl/sstw_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sstw_pkg
// Shared types, constants and the segment lookup for the seven-segment
// text writer and scanner.
// ----------------------------------------------------------------------------
package sstw_pkg;

    localparam int DIGIT_COUNT_DEF = 4;

    localparam int CH_W    = 8;
    localparam int START_W = 3;
    localparam int SEG_W   = 8;
    localparam int SEL_W   = 8;
    localparam int WORD_W  = SEG_W + SEL_W;
    localparam int COUNT_W = 3;

    // Item kinds
    typedef enum logic {
        OP_TICK = 1'b0,
        OP_CHAR = 1'b1
    } t_op;

    localparam logic [CH_W-1:0] CH_ZERO = 8'h30;
    localparam logic [CH_W-1:0] CH_NINE = 8'h39;
    localparam logic [CH_W-1:0] CH_DOT  = 8'h2E;

    // Active-low segments, bit 7 is the decimal point
    localparam logic [SEG_W-1:0] SEG_DOT_ONLY = 8'h7F;
    localparam logic [SEG_W-1:0] SEG_DP_MASK  = 8'h7F;
    localparam logic [SEG_W-1:0] SEG_BLANK    = 8'hFF;

    typedef struct packed {
        logic             is_digit;
        logic             is_dot;
        logic [SEG_W-1:0] seg;
    } t_char_info;

    function automatic logic [SEG_W-1:0] seg_of(input logic [3:0] digit);
        logic [SEG_W-1:0] seg;
        unique case (digit)
            4'd0:    seg = 8'hC0;
            4'd1:    seg = 8'hF9;
            4'd2:    seg = 8'hA4;
            4'd3:    seg = 8'hB0;
            4'd4:    seg = 8'h99;
            4'd5:    seg = 8'h92;
            4'd6:    seg = 8'h82;
            4'd7:    seg = 8'hF8;
            4'd8:    seg = 8'h80;
            4'd9:    seg = 8'h90;
            default: seg = SEG_BLANK;
        endcase
        return seg;
    endfunction

endpackage
`default_nettype wire

// File: rtl/sstw_char_decode.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sstw_char_decode
// Classifies a character code and looks up its segment pattern.
// ----------------------------------------------------------------------------
module sstw_char_decode
    import sstw_pkg::*;
(
    input  wire logic [CH_W-1:0] i_ch,
    output t_char_info           o_info
);

    always_comb begin
        o_info.is_digit = (i_ch >= CH_ZERO) && (i_ch <= CH_NINE);
        o_info.is_dot   = (i_ch == CH_DOT);
        // '0'..'9' carry their value in the low nibble
        o_info.seg      = seg_of(i_ch[3:0]);
    end

endmodule
`default_nettype wire

// File: rtl/sstw_display_state.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sstw_display_state
// Digit store, string write pointer and scan pointer. Computes the result
// of the item in the input register and commits state on a step.
// ----------------------------------------------------------------------------
module sstw_display_state
    import sstw_pkg::*;
#(
    parameter int DIGIT_COUNT = DIGIT_COUNT_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_step,
    input  wire logic               i_op,
    input  wire logic [START_W-1:0] i_anchor,
    input  wire logic               i_first,
    input  wire logic               i_clear,
    input  t_char_info              i_info,
    output logic [WORD_W-1:0]       o_shift_word,
    output logic [COUNT_W-1:0]      o_count,
    output logic                    o_overflow,
    output logic                    o_ignored
);

    localparam int POS_MAX = (DIGIT_COUNT > 7) ? DIGIT_COUNT : 7;
    localparam int POS_W   = $clog2(POS_MAX + 1);
    localparam int IDX_W   = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;
    localparam logic [POS_W-1:0] POS_DC   = POS_W'(DIGIT_COUNT);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(DIGIT_COUNT - 1);

    logic [SEG_W-1:0] r_store [DIGIT_COUNT];
    logic [SEG_W-1:0] n_store [DIGIT_COUNT];
    logic [POS_W-1:0] r_wpos,    n_wpos;
    logic [POS_W-1:0] r_sstart,  n_sstart;
    logic             r_stopped, n_stopped;
    logic [IDX_W-1:0] r_scan,    n_scan;

    logic [POS_W-1:0] wpos0, sstart0, wpos_eff, diff;
    logic             stopped0, have, dot_back, do_write;
    logic [IDX_W-1:0] wr_idx;
    logic [SEG_W-1:0] wr_data, scan_seg;
    logic [SEL_W-1:0] scan_sel;

    always_comb begin
        // start-of-string handling only applies to characters
        if (t_op'(i_op) == OP_CHAR && i_first) begin
            wpos0    = POS_W'(i_anchor);
            sstart0  = POS_W'(i_anchor);
            stopped0 = 1'b0;
        end else begin
            wpos0    = r_wpos;
            sstart0  = r_sstart;
            stopped0 = r_stopped;
        end

        have     = i_info.is_digit || i_info.is_dot;
        dot_back = i_info.is_dot && (wpos0 != sstart0) && (wpos0 != '0);
        wpos_eff = dot_back ? wpos0 - POS_W'(1) : wpos0;
        wr_idx   = wpos_eff[IDX_W-1:0];
        // a point after a digit clears that digit's DP bit in place
        wr_data  = i_info.is_digit ? i_info.seg : SEG_DOT_ONLY;

        n_wpos    = wpos0;
        n_sstart  = sstart0;
        n_stopped = stopped0;
        n_scan    = r_scan;
        do_write  = 1'b0;
        o_ignored = 1'b0;

        if (t_op'(i_op) == OP_TICK) begin
            n_scan = (r_scan == IDX_LAST) ? '0 : r_scan + IDX_W'(1);
        end else if (!stopped0) begin
            if (!have) begin
                o_ignored = 1'b1;
            end else if (wpos_eff >= POS_DC) begin
                n_stopped = 1'b1;
                n_wpos    = wpos_eff;
            end else begin
                do_write = 1'b1;
                n_wpos   = wpos_eff + POS_W'(1);
            end
        end

        for (int i = 0; i < DIGIT_COUNT; i++) begin
            n_store[i] = i_clear ? '0 : r_store[i];
            if (do_write && wr_idx == IDX_W'(i)) begin
                n_store[i] = dot_back ? (n_store[i] & SEG_DP_MASK) : wr_data;
            end
        end

        scan_sel = SEL_W'(1) << r_scan;
        scan_seg = i_clear ? '0 : r_store[r_scan];
        o_shift_word = (t_op'(i_op) == OP_TICK) ? {scan_seg, scan_sel} : '0;

        diff       = n_wpos - n_sstart;
        o_count    = (n_wpos < n_sstart) ? '0 : diff[COUNT_W-1:0];
        o_overflow = n_stopped;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < DIGIT_COUNT; i++) begin
                r_store[i] <= '0;
            end
            r_wpos    <= '0;
            r_sstart  <= '0;
            r_stopped <= 1'b0;
            r_scan    <= '0;
        end else if (i_step) begin
            for (int i = 0; i < DIGIT_COUNT; i++) begin
                r_store[i] <= n_store[i];
            end
            r_wpos    <= n_wpos;
            r_sstart  <= n_sstart;
            r_stopped <= n_stopped;
            r_scan    <= n_scan;
        end
    end

endmodule
`default_nettype wire

// File: rtl/seven_segment_text_writer_and_scanner.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// seven_segment_text_writer_and_scanner
// Multiplexed common-anode seven-segment driver: character items write a
// digit store, tick items scan it out as a shift-register word.
// ----------------------------------------------------------------------------
//
//  channel | handshake           | payload
//  --------+---------------------+------------------------------------------
//  input   | i_valid / o_stall   | i_op i_ch i_anchor i_first i_clear
//  output  | o_valid / i_stall   | o_shift_word o_count o_overflow o_ignored
//
//  An accepted item sits in the input register; when it advances, decode and
//  state update load the result register, which drives o_valid. One item per
//  cycle is sustained while i_stall is low; the state update loop is combinational.
//  Synchronous active-low reset clears the digit store, pointers and both
//  valid flags. o_stall rises only when the input register is full and the
//  result register is full and stalled; an empty input register always loads.
// ----------------------------------------------------------------------------
module seven_segment_text_writer_and_scanner
    import sstw_pkg::*;
#(
    parameter int DIGIT_COUNT = DIGIT_COUNT_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    // item input
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire logic               i_op,
    input  wire logic [CH_W-1:0]    i_ch,
    input  wire logic [START_W-1:0] i_anchor,
    input  wire logic               i_first,
    input  wire logic               i_clear,
    // result output
    output logic                    o_valid,
    input  wire logic               i_stall,
    output logic [WORD_W-1:0]       o_shift_word,
    output logic [COUNT_W-1:0]      o_count,
    output logic                    o_overflow,
    output logic                    o_ignored
);

    // input register
    logic               r_in_valid;
    logic               r_op;
    logic [CH_W-1:0]    r_ch;
    logic [START_W-1:0] r_anchor;
    logic               r_first;
    logic               r_clear;

    // result register
    logic               r_out_valid;
    logic [WORD_W-1:0]  r_shift_word;
    logic [COUNT_W-1:0] r_count;
    logic               r_overflow;
    logic               r_ignored;

    logic               advance;
    logic               in_load;
    t_char_info         info;
    logic [WORD_W-1:0]  n_shift_word;
    logic [COUNT_W-1:0] n_count;
    logic               n_overflow;
    logic               n_ignored;

    // The held item moves on when the result slot is free or being taken.
    assign advance = r_in_valid && (!r_out_valid || !i_stall);
    assign o_stall = r_in_valid && !advance;
    assign in_load = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_load) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_load) begin
            r_op     <= i_op;
            r_ch     <= i_ch;
            r_anchor <= i_anchor;
            r_first  <= i_first;
            r_clear  <= i_clear;
        end
    end

    sstw_char_decode u_decode (
        .i_ch   (r_ch),
        .o_info (info)
    );

    // Digit store, pointers and result computation; state commits on advance.
    sstw_display_state #(
        .DIGIT_COUNT (DIGIT_COUNT)
    ) u_state (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (advance),
        .i_op         (r_op),
        .i_anchor     (r_anchor),
        .i_first      (r_first),
        .i_clear      (r_clear),
        .i_info       (info),
        .o_shift_word (n_shift_word),
        .o_count      (n_count),
        .o_overflow   (n_overflow),
        .o_ignored    (n_ignored)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_shift_word <= n_shift_word;
            r_count      <= n_count;
            r_overflow   <= n_overflow;
            r_ignored    <= n_ignored;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_shift_word = r_shift_word;
    assign o_count      = r_count;
    assign o_overflow   = r_overflow;
    assign o_ignored    = r_ignored;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------

    // Scan words carry exactly one digit select; character results carry none.
    a_select_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_shift_word[SEL_W-1:0] == '0) ||
                    $onehot(o_shift_word[SEL_W-1:0]))
        else $error("digit select is not one-hot");

    // An unknown character leaves the string running and emits no scan word.
    a_ignored_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_ignored |-> !o_overflow && (o_shift_word == '0))
        else $error("ignored character with overflow or scan word");

    // An item leaving the input register always lands in the result register.
    a_advance_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !o_stall |=> o_valid)
        else $error("advanced item did not reach the output");

    // The string length never exceeds the number of digits.
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (32'(o_count) <= DIGIT_COUNT))
        else $error("count beyond digit count");

endmodule
`default_nettype wire

// File: sim/seven_segment_text_writer_and_scanner_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// seven_segment_text_writer_and_scanner_test
// Drives character and scan-tick items into the display driver, predicts
// each result from a behavioral copy of the digit store and string pointers,
// and checks every result in order under random sender gaps and receiver
// stalls.
// ----------------------------------------------------------------------------
module seven_segment_text_writer_and_scanner_test;
    import sstw_pkg::*;

    localparam int DIGITS     = DIGIT_COUNT_DEF;
    localparam int CYCLE_MAX  = 200000;   // run watchdog
    localparam int HOLD_LEN   = 50;       // long receiver hold-off
    localparam int DRAIN_WAIT = 8;        // pipeline is two deep, with margin

    // Segment patterns for '0'..'9' (active low, bit 7 = decimal point)
    localparam logic [SEG_W-1:0] DIGIT_SEGS [10] = '{
        8'hC0, 8'hF9, 8'hA4, 8'hB0, 8'h99, 8'h92, 8'h82, 8'hF8, 8'h80, 8'h90
    };

    typedef struct packed {
        t_op                op;
        logic [CH_W-1:0]    ch;
        logic [START_W-1:0] anchor;
        logic               first;
        logic               clear;
    } text_item_t;

    typedef struct packed {
        logic [WORD_W-1:0]  shift_word;
        logic [COUNT_W-1:0] count;
        logic               overflow;
        logic               ignored;
    } scan_result_t;

    // ------------------------------------------------------------------
    // DUT hookup; every input starts at a known value
    // ------------------------------------------------------------------
    logic               i_clk       = 1'b0;
    logic               i_rst_n     = 1'b0;
    logic               i_valid     = 1'b0;
    t_op                i_op        = OP_TICK;
    logic [CH_W-1:0]    i_ch        = '0;
    logic [START_W-1:0] i_anchor    = '0;
    logic               i_first     = 1'b0;
    logic               i_clear     = 1'b0;
    logic               i_stall     = 1'b0;
    logic               o_stall;
    logic               o_valid;
    logic [WORD_W-1:0]  o_shift_word;
    logic [COUNT_W-1:0] o_count;
    logic               o_overflow;
    logic               o_ignored;

    seven_segment_text_writer_and_scanner dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_op         (i_op),
        .i_ch         (i_ch),
        .i_anchor     (i_anchor),
        .i_first      (i_first),
        .i_clear      (i_clear),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_shift_word (o_shift_word),
        .o_count      (o_count),
        .o_overflow   (o_overflow),
        .o_ignored    (o_ignored)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Shadow copy of the display state
    // ------------------------------------------------------------------
    logic [SEG_W-1:0]   seg_store [DIGITS];
    logic [START_W-1:0] wr_pos      = '0;
    logic [START_W-1:0] str_start   = '0;
    logic               str_stopped = 1'b0;
    logic [1:0]         scan_pos    = '0;

    initial begin
        foreach (seg_store[i]) seg_store[i] = '0;
    end

    // Updates the shadow state with one accepted item and returns its result.
    function automatic scan_result_t predict_scan_result(input text_item_t it);
        scan_result_t     r;
        logic [SEG_W-1:0] seg;
        logic             drawable;
        r = '0;
        seg = '0;
        drawable = 1'b1;
        if (it.clear) begin
            foreach (seg_store[i]) seg_store[i] = '0;
        end
        if (it.op == OP_TICK) begin
            // one-hot select low, selected digit's segments high
            r.shift_word = (WORD_W'(1) << scan_pos) | {seg_store[scan_pos], SEL_W'(0)};
            scan_pos = (scan_pos == DIGITS - 1) ? '0 : scan_pos + 1'b1;
        end else begin
            if (it.first) begin
                str_start   = it.anchor;
                wr_pos      = it.anchor;
                str_stopped = 1'b0;
            end
            // a stopped string swallows everything until the next first
            if (!str_stopped) begin
                if (it.ch >= CH_ZERO && it.ch <= CH_NINE) begin
                    seg = DIGIT_SEGS[4'(it.ch - CH_ZERO)];
                end else if (it.ch == CH_DOT) begin
                    // point joins the previous digit of this string, else stands alone
                    if (wr_pos != str_start && wr_pos != 0) begin
                        wr_pos = wr_pos - 1'b1;
                        seg = seg_store[wr_pos[1:0]] & SEG_DP_MASK;
                    end else begin
                        seg = SEG_DOT_ONLY;
                    end
                end else begin
                    drawable  = 1'b0;
                    r.ignored = 1'b1;
                end
                if (drawable) begin
                    if (wr_pos >= DIGITS) begin
                        str_stopped = 1'b1;
                    end else begin
                        seg_store[wr_pos[1:0]] = seg;
                        wr_pos = wr_pos + 1'b1;
                    end
                end
            end
        end
        r.count    = (wr_pos < str_start) ? '0 : COUNT_W'(wr_pos - str_start);
        r.overflow = str_stopped;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Item queues, phase knobs and bookkeeping
    // ------------------------------------------------------------------
    text_item_t   items_to_send [$];
    scan_result_t results_due [$];
    text_item_t   next_item;
    scan_result_t want;

    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned hold_requests  = 0;   // bumped by the stimulus process
    int unsigned hold_served    = 0;   // receiver catches up in its own process
    int unsigned hold_left      = 0;
    int unsigned pushed_count   = 0;
    int unsigned accepted_count = 0;
    int unsigned mismatch_count = 0;
    int unsigned cycle_count    = 0;
    logic        item_taken     = 1'b0;

    // ------------------------------------------------------------------
    // Sender: falling-edge driver, payload held while stalled
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (!i_valid || item_taken) begin
            if (items_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                next_item   = items_to_send.pop_front();
                i_valid     <= 1'b1;
                i_op        <= next_item.op;
                i_ch        <= next_item.ch;
                i_anchor    <= next_item.anchor;
                i_first     <= next_item.first;
                i_clear     <= next_item.clear;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: random stalls, plus a counted hold-off on request
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (hold_served != hold_requests) begin
            hold_served <= hold_requests;
            hold_left   <= HOLD_LEN - 1;
            i_stall     <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            i_stall   <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    task automatic report_mismatch(input string field, input logic [WORD_W-1:0] exp_v,
                                   input logic [WORD_W-1:0] act_v);
        $display("%0t ns: %s mismatch, expected 0x%0h, got 0x%0h", $time, field, exp_v, act_v);
        mismatch_count++;
    endtask

    // ------------------------------------------------------------------
    // Rising edge: record accepted items, check results, watchdog
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        item_taken  <= i_rst_n && i_valid && !o_stall;
        if (i_rst_n && i_valid && !o_stall) begin
            accepted_count <= accepted_count + 1;
            results_due.push_back(predict_scan_result(
                text_item_t'{i_op, i_ch, i_anchor, i_first, i_clear}));
        end
        if (i_rst_n && o_valid && !i_stall) begin
            if (results_due.size() == 0) begin
                $display("%0t ns: unexpected result, expected none, got word 0x%0h count %0d",
                         $time, o_shift_word, o_count);
                mismatch_count++;
            end else begin
                want = results_due.pop_front();
                if (o_shift_word !== want.shift_word)
                    report_mismatch("shift_word", want.shift_word, o_shift_word);
                if (o_count !== want.count)
                    report_mismatch("count", want.count, o_count);
                if (o_overflow !== want.overflow)
                    report_mismatch("overflow", want.overflow, o_overflow);
                if (o_ignored !== want.ignored)
                    report_mismatch("ignored", want.ignored, o_ignored);
            end
        end
        if (cycle_count > CYCLE_MAX) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic push_item(input t_op op, input logic [CH_W-1:0] ch,
                             input logic [START_W-1:0] pos, input logic first,
                             input logic clear);
        items_to_send.push_back(text_item_t'{op, ch, pos, first, clear});
        pushed_count++;
    endtask

    // Mostly well-formed strings with ticks woven in, some bare ticks, some noise.
    task automatic push_random_items(input int unsigned n);
        int unsigned made;
        int unsigned pick;
        int unsigned len;
        logic [START_W-1:0] pos;
        logic [CH_W-1:0]    ch;
        made = 0;
        while (made < n) begin
            pick = $urandom_range(99);
            if (pick < 20) begin
                push_item(OP_TICK, CH_W'($urandom), START_W'($urandom_range(4)),
                          1'($urandom), ($urandom_range(19) == 0));
                made++;
            end else if (pick < 85) begin
                pos = ($urandom_range(9) == 0) ? START_W'(4) : START_W'($urandom_range(3));
                len = $urandom_range(6, 1);
                for (int k = 0; k < len; k++) begin
                    pick = $urandom_range(99);
                    if (pick < 65)
                        ch = CH_ZERO + CH_W'($urandom_range(9));
                    else if (pick < 88)
                        ch = CH_DOT;
                    else
                        ch = CH_W'($urandom);
                    push_item(OP_CHAR, ch, (k == 0) ? pos : START_W'($urandom_range(4)),
                              (k == 0), ($urandom_range(29) == 0));
                    made++;
                    if ($urandom_range(4) == 0) begin
                        push_item(OP_TICK, CH_W'($urandom), '0, 1'b0,
                                  ($urandom_range(29) == 0));
                        made++;
                    end
                end
            end else begin
                // raw noise over the full op, code and flag ranges, start positions 0 to 4
                push_item(t_op'($urandom_range(1)), CH_W'($urandom),
                          START_W'($urandom_range(4)), 1'($urandom), 1'($urandom));
                made++;
            end
        end
    endtask

    // Sender pauses here until the block has returned everything it owes.
    task automatic wait_drained;
        do @(negedge i_clk);
        while (accepted_count != pushed_count || results_due.size() != 0);
    endtask

    task automatic run_phase(input int unsigned send_pct, input int unsigned recv_pct,
                             input int unsigned n, input logic long_hold);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        if (long_hold)
            hold_requests++;
        push_random_items(n);
        wait_drained();
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: character before any string start, then a tick that
        // carries a start which it must ignore
        push_item(OP_CHAR, CH_ZERO + 8'd5, 3'd0, 1'b0, 1'b0);
        push_item(OP_TICK, 8'h00, 3'd3, 1'b1, 1'b0);
        // leading point, point after a digit, fill to the last digit, run past it
        push_item(OP_CHAR, CH_DOT, 3'd0, 1'b1, 1'b0);
        push_item(OP_CHAR, CH_ZERO + 8'd8, 3'd0, 1'b0, 1'b0);
        push_item(OP_CHAR, CH_DOT, 3'd0, 1'b0, 1'b0);
        push_item(OP_CHAR, CH_ZERO, 3'd0, 1'b0, 1'b0);
        push_item(OP_CHAR, CH_NINE, 3'd0, 1'b0, 1'b0);
        push_item(OP_CHAR, CH_ZERO + 8'd1, 3'd0, 1'b0, 1'b0);
        // stopped string swallows an undrawable character
        push_item(OP_CHAR, 8'h41, 3'd0, 1'b0, 1'b0);
        // start past the last digit: just outside the digit range is ignored,
        // a point stops the string
        push_item(OP_CHAR, CH_NINE + 8'd1, 3'd4, 1'b1, 1'b0);
        push_item(OP_CHAR, CH_ZERO - 8'd1, 3'd4, 1'b0, 1'b0);
        push_item(OP_CHAR, CH_DOT, 3'd4, 1'b0, 1'b0);
        // all-ones and all-zeros codes, points stacked mid-display
        push_item(OP_CHAR, 8'hFF, 3'd2, 1'b1, 1'b0);
        push_item(OP_CHAR, CH_DOT, 3'd0, 1'b0, 1'b0);
        push_item(OP_CHAR, CH_DOT, 3'd0, 1'b0, 1'b0);
        push_item(OP_CHAR, 8'h00, 3'd7, 1'b0, 1'b0);
        // clear without a new string keeps the write position
        push_item(OP_CHAR, CH_ZERO + 8'd3, 3'd0, 1'b0, 1'b1);
        // full scan sweep across the wrap, clear on a tick
        push_item(OP_TICK, 8'hFF, 3'd7, 1'b0, 1'b0);
        push_item(OP_TICK, 8'h00, 3'd0, 1'b0, 1'b0);
        push_item(OP_TICK, 8'hAA, 3'd5, 1'b1, 1'b0);
        push_item(OP_TICK, 8'h55, 3'd2, 1'b0, 1'b1);
        // digit straight into a start past the end
        push_item(OP_CHAR, CH_ZERO + 8'd7, 3'd4, 1'b1, 1'b0);
        push_item(OP_TICK, 8'h00, 3'd0, 1'b0, 1'b0);
        // point after a digit that a clear has just wiped
        push_item(OP_CHAR, CH_ZERO + 8'd2, 3'd0, 1'b1, 1'b0);
        push_item(OP_CHAR, CH_DOT, 3'd0, 1'b0, 1'b1);
        wait_drained();

        // Random phases: free-running, sender gaps, receiver stalls, both,
        // then a long receiver hold-off so the input side backs up
        run_phase(0, 0, 180, 1'b0);
        run_phase(61, 0, 180, 1'b0);
        run_phase(0, 61, 180, 1'b0);
        run_phase(26, 26, 180, 1'b0);
        run_phase(0, 0, 180, 1'b1);

        repeat (DRAIN_WAIT) @(posedge i_clk);
        @(negedge i_clk);
        if (mismatch_count == 0 && results_due.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
